// ===== hdl/dtfa_pkg.sv =====
// Package for the dictionary tensor field accumulator: sizes, codes, the
// queue item type and the saturation helpers. Depends on nothing.
package dtfa_pkg;

  localparam int unsigned DICT_ENTRIES = 4096;
  localparam int unsigned VALUE_BITS   = 24;

  localparam int unsigned ADDR_W   = (DICT_ENTRIES > 1) ? $clog2(DICT_ENTRIES) : 1;
  localparam int unsigned IDX_W    = 12;
  localparam int unsigned SEL_W    = 3;
  localparam int unsigned WORD_W   = 24;
  localparam int unsigned MOM_W    = 24;
  localparam int unsigned MASK_W   = 6;
  localparam int unsigned COMP_N   = 6;
  localparam int unsigned AXIS_N   = 3;
  localparam int unsigned FIELD_W  = 48;
  localparam int unsigned SUM_W    = 56;
  localparam int unsigned T_W      = VALUE_BITS + 1;
  localparam int unsigned PROD_W   = T_W + MOM_W;
  localparam int unsigned TERM_W   = PROD_W + 2;
  localparam int unsigned ACC_W    = ((TERM_W > SUM_W) ? TERM_W : SUM_W) + 1;
  localparam int unsigned WIDE_W   = 34;
  localparam int unsigned Q_DEPTH  = 4;
  localparam int unsigned Q_PTR_W  = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W  = $clog2(Q_DEPTH + 1);

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_PAIR = 1'b1;

  localparam logic [SEL_W-1:0] COMP_XX = 3'd0;
  localparam logic [SEL_W-1:0] COMP_XY = 3'd1;
  localparam logic [SEL_W-1:0] COMP_XZ = 3'd2;
  localparam logic [SEL_W-1:0] COMP_YY = 3'd3;
  localparam logic [SEL_W-1:0] COMP_YZ = 3'd4;
  localparam logic [SEL_W-1:0] COMP_ZZ = 3'd5;

  // tensor component feeding row a, moment axis j
  localparam logic [SEL_W-1:0] TIDX [AXIS_N][AXIS_N] = '{
    '{COMP_XX, COMP_XY, COMP_XZ},
    '{COMP_XY, COMP_YY, COMP_YZ},
    '{COMP_XZ, COMP_YZ, COMP_ZZ}
  };

  localparam logic signed [WIDE_W-1:0] COEF_MAX =
    WIDE_W'((64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1);
  localparam logic signed [WIDE_W-1:0] COEF_MIN = -COEF_MAX - WIDE_W'(1);

  typedef struct packed {
    logic                                is_pair;
    logic                                wr_en;
    logic                                in_range;
    logic [ADDR_W-1:0]                   addr;
    logic [SEL_W-1:0]                    comp;
    logic signed [VALUE_BITS-1:0]        coef;
    logic [MASK_W-1:0]                   mask;
    logic                                skip;
    logic                                last;
    logic signed [MOM_W-1:0]             mx;
    logic signed [MOM_W-1:0]             my;
    logic signed [MOM_W-1:0]             mz;
  } dtfa_item_t;

  typedef struct packed {
    logic       valid;
    dtfa_item_t item;
  } dtfa_head_t;

  function automatic logic signed [VALUE_BITS-1:0] sat_coef(
    input logic signed [WORD_W-1:0] w
  );
    logic signed [WIDE_W-1:0] v;
    v = WIDE_W'(w);
    if (v > COEF_MAX) begin
      v = COEF_MAX;
    end else if (v < COEF_MIN) begin
      v = COEF_MIN;
    end
    return VALUE_BITS'(v);
  endfunction

  function automatic logic signed [SUM_W-1:0] sat_sum(
    input logic signed [ACC_W-1:0] v
  );
    logic [ACC_W-SUM_W:0] hi;
    hi = v[ACC_W-1:SUM_W-1];
    if ((&hi) || !(|hi)) begin
      return v[SUM_W-1:0];
    end else if (v[ACC_W-1]) begin
      return {1'b1, {(SUM_W-1){1'b0}}};
    end else begin
      return {1'b0, {(SUM_W-1){1'b1}}};
    end
  endfunction

  function automatic logic signed [FIELD_W-1:0] sat_field(
    input logic signed [SUM_W-1:0] v
  );
    logic [SUM_W-FIELD_W:0] hi;
    hi = v[SUM_W-1:FIELD_W-1];
    if ((&hi) || !(|hi)) begin
      return v[FIELD_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(FIELD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(FIELD_W-1){1'b1}}};
    end
  endfunction

endpackage

// ===== hdl/dtfa_front.sv =====
// Front end: decodes each request into a queue item (load write or pair)
// and buffers it in a short queue. Depends on dtfa_pkg.
module dtfa_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_cmd,
  input  logic [dtfa_pkg::IDX_W-1:0]           in_entry_index,
  input  logic [dtfa_pkg::SEL_W-1:0]           in_component_select,
  input  logic signed [dtfa_pkg::WORD_W-1:0]   in_coefficient_word,
  input  logic [dtfa_pkg::MASK_W-1:0]          in_sign_mask,
  input  logic                                 in_skip_pair,
  input  logic signed [dtfa_pkg::MOM_W-1:0]    in_moment_x,
  input  logic signed [dtfa_pkg::MOM_W-1:0]    in_moment_y,
  input  logic signed [dtfa_pkg::MOM_W-1:0]    in_moment_z,
  input  logic                                 in_last_of_target,
  output dtfa_pkg::dtfa_head_t                 head,
  input  logic                                 pop
);

  dtfa_pkg::dtfa_item_t               item_nxt;
  dtfa_pkg::dtfa_item_t               q_r [dtfa_pkg::Q_DEPTH];
  logic [dtfa_pkg::Q_PTR_W-1:0]       wr_ptr_r;
  logic [dtfa_pkg::Q_PTR_W-1:0]       rd_ptr_r;
  logic [dtfa_pkg::Q_CNT_W-1:0]       cnt_r;
  logic [dtfa_pkg::Q_CNT_W-1:0]       cnt_nxt;
  logic                               push;
  logic                               do_pop;
  logic                               in_range;

  always_comb begin
    in_range          = 32'(in_entry_index) < 32'(dtfa_pkg::DICT_ENTRIES);
    item_nxt.is_pair  = (in_cmd == dtfa_pkg::CMD_PAIR);
    item_nxt.wr_en    = (in_cmd == dtfa_pkg::CMD_LOAD) && in_range &&
                        (in_component_select <= dtfa_pkg::COMP_ZZ);
    item_nxt.in_range = in_range;
    item_nxt.addr     = dtfa_pkg::ADDR_W'(in_entry_index);
    item_nxt.comp     = in_component_select;
    item_nxt.coef     = dtfa_pkg::sat_coef(in_coefficient_word);
    item_nxt.mask     = in_sign_mask;
    item_nxt.skip     = in_skip_pair;
    item_nxt.last     = in_last_of_target;
    item_nxt.mx       = in_moment_x;
    item_nxt.my       = in_moment_y;
    item_nxt.mz       = in_moment_z;
  end

  assign in_ready   = (cnt_r != dtfa_pkg::Q_CNT_W'(dtfa_pkg::Q_DEPTH));
  assign push       = in_valid && in_ready;
  assign head.valid = (cnt_r != '0);
  assign head.item  = q_r[rd_ptr_r];
  assign do_pop     = pop && head.valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + dtfa_pkg::Q_CNT_W'(1);
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - dtfa_pkg::Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= item_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + dtfa_pkg::Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + dtfa_pkg::Q_PTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= dtfa_pkg::Q_CNT_W'(dtfa_pkg::Q_DEPTH))
    else $error("queue count beyond depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == dtfa_pkg::Q_CNT_W'(dtfa_pkg::Q_DEPTH)) || (cnt_r == '0) |->
      wr_ptr_r == rd_ptr_r)
    else $error("queue pointers disagree with count");

endmodule

// ===== hdl/dtfa_back.sv =====
// Back end: coefficient banks, sign/multiply/reduce pipeline, saturating
// accumulators and the result register. Depends on dtfa_pkg.
module dtfa_back (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  dtfa_pkg::dtfa_head_t                  head,
  output logic                                  pop,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [dtfa_pkg::FIELD_W-1:0]   out_field_x,
  output logic signed [dtfa_pkg::FIELD_W-1:0]   out_field_y,
  output logic signed [dtfa_pkg::FIELD_W-1:0]   out_field_z
);

  logic                                 en;
  logic signed [dtfa_pkg::VALUE_BITS-1:0] rd_data [dtfa_pkg::COMP_N];

  logic                                 s1_v_r;
  logic                                 s1_in_range_r;
  logic [dtfa_pkg::MASK_W-1:0]          s1_mask_r;
  logic                                 s1_skip_r;
  logic                                 s1_last_r;
  logic signed [dtfa_pkg::MOM_W-1:0]    s1_m_r [dtfa_pkg::AXIS_N];

  logic signed [dtfa_pkg::T_W-1:0]      t_nxt [dtfa_pkg::COMP_N];
  logic                                 s2_v_r;
  logic                                 s2_skip_r;
  logic                                 s2_last_r;
  logic signed [dtfa_pkg::T_W-1:0]      s2_t_r [dtfa_pkg::COMP_N];
  logic signed [dtfa_pkg::MOM_W-1:0]    s2_m_r [dtfa_pkg::AXIS_N];

  logic                                 s3_v_r;
  logic                                 s3_skip_r;
  logic                                 s3_last_r;
  logic signed [dtfa_pkg::PROD_W-1:0]   s3_p_r [dtfa_pkg::AXIS_N][dtfa_pkg::AXIS_N];

  logic                                 s4_v_r;
  logic                                 s4_skip_r;
  logic                                 s4_last_r;
  logic signed [dtfa_pkg::TERM_W-1:0]   s4_term_r [dtfa_pkg::AXIS_N];

  logic signed [dtfa_pkg::SUM_W-1:0]    sum_r   [dtfa_pkg::AXIS_N];
  logic signed [dtfa_pkg::SUM_W-1:0]    sum_nxt [dtfa_pkg::AXIS_N];
  logic                                 out_valid_r;
  logic signed [dtfa_pkg::FIELD_W-1:0]  out_field_r [dtfa_pkg::AXIS_N];

  // hold the whole pipeline while a result waits
  assign en  = !(out_valid_r && !out_ready);
  assign pop = en && head.valid;

  for (genvar k = 0; k < dtfa_pkg::COMP_N; k++) begin : g_bank
    logic signed [dtfa_pkg::VALUE_BITS-1:0] mem_r [dtfa_pkg::DICT_ENTRIES];
    logic signed [dtfa_pkg::VALUE_BITS-1:0] rd_r;
    always_ff @(posedge clk) begin
      if (pop && head.item.wr_en && (head.item.comp == dtfa_pkg::SEL_W'(k))) begin
        mem_r[head.item.addr] <= head.item.coef;
      end
      if (en) begin
        rd_r <= mem_r[head.item.addr];
      end
    end
    assign rd_data[k] = rd_r;
  end

  always_comb begin
    for (int k = 0; k < dtfa_pkg::COMP_N; k++) begin
      t_nxt[k] = s1_in_range_r ? dtfa_pkg::T_W'(rd_data[k]) : '0;
      if (s1_mask_r[k]) begin
        t_nxt[k] = -t_nxt[k];
      end
    end
  end

  always_comb begin
    for (int a = 0; a < dtfa_pkg::AXIS_N; a++) begin
      sum_nxt[a] = dtfa_pkg::sat_sum(dtfa_pkg::ACC_W'(sum_r[a]) +
                                     (s4_skip_r ? '0 : dtfa_pkg::ACC_W'(s4_term_r[a])));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_in_range_r <= head.item.in_range;
      s1_mask_r     <= head.item.mask;
      s1_skip_r     <= head.item.skip;
      s1_last_r     <= head.item.last;
      s1_m_r[0]     <= head.item.mx;
      s1_m_r[1]     <= head.item.my;
      s1_m_r[2]     <= head.item.mz;

      s2_skip_r <= s1_skip_r;
      s2_last_r <= s1_last_r;
      s2_t_r    <= t_nxt;
      s2_m_r    <= s1_m_r;

      s3_skip_r <= s2_skip_r;
      s3_last_r <= s2_last_r;
      for (int a = 0; a < dtfa_pkg::AXIS_N; a++) begin
        for (int j = 0; j < dtfa_pkg::AXIS_N; j++) begin
          s3_p_r[a][j] <= dtfa_pkg::PROD_W'(s2_t_r[dtfa_pkg::TIDX[a][j]]) *
                          dtfa_pkg::PROD_W'(s2_m_r[j]);
        end
      end

      s4_skip_r <= s3_skip_r;
      s4_last_r <= s3_last_r;
      for (int a = 0; a < dtfa_pkg::AXIS_N; a++) begin
        s4_term_r[a] <= dtfa_pkg::TERM_W'(s3_p_r[a][0]) +
                        dtfa_pkg::TERM_W'(s3_p_r[a][1]) +
                        dtfa_pkg::TERM_W'(s3_p_r[a][2]);
      end

      if (s4_v_r && s4_last_r) begin
        for (int a = 0; a < dtfa_pkg::AXIS_N; a++) begin
          out_field_r[a] <= dtfa_pkg::sat_field(sum_nxt[a]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int a = 0; a < dtfa_pkg::AXIS_N; a++) begin
        sum_r[a] <= '0;
      end
    end else if (en) begin
      s1_v_r      <= pop && head.item.is_pair;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r;
      s4_v_r      <= s3_v_r;
      out_valid_r <= s4_v_r && s4_last_r;
      if (s4_v_r) begin
        for (int a = 0; a < dtfa_pkg::AXIS_N; a++) begin
          sum_r[a] <= s4_last_r ? '0 : sum_nxt[a];
        end
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_field_x = out_field_r[0];
  assign out_field_y = out_field_r[1];
  assign out_field_z = out_field_r[2];

  a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    en && s4_v_r && s4_last_r |=> (sum_r[0] == '0) && (sum_r[1] == '0) && (sum_r[2] == '0))
    else $error("sums not cleared after last pair");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s4_v_r && s4_last_r))
    else $error("result without a last pair");

  a_skip_no_effect: assert property (@(posedge clk) disable iff (!rst_n)
    en && s4_v_r && s4_skip_r && !s4_last_r |=> $stable(sum_r[0]) && $stable(sum_r[1]) &&
      $stable(sum_r[2]))
    else $error("skipped pair changed the sums");

endmodule

// ===== hdl/dictionary_tensor_field_accumulator.sv =====
// Top level of the dictionary tensor field accumulator: front queue and back
// pipeline. Depends on dtfa_pkg, dtfa_front, dtfa_back.
// Throughput: one request per cycle, loads and pairs alike, while out_ready holds.
// A last pair's result passes the queue, bank read, sign, multiply, reduce and
// accumulate registers in that order before out_valid rises.
// Reset clears the queue, pipeline valids and sums; dictionary banks keep no reset.
module dictionary_tensor_field_accumulator (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_cmd,
  input  logic [dtfa_pkg::IDX_W-1:0]           in_entry_index,
  input  logic [dtfa_pkg::SEL_W-1:0]           in_component_select,
  input  logic signed [dtfa_pkg::WORD_W-1:0]   in_coefficient_word,
  input  logic [dtfa_pkg::MASK_W-1:0]          in_sign_mask,
  input  logic                                 in_skip_pair,
  input  logic signed [dtfa_pkg::MOM_W-1:0]    in_moment_x,
  input  logic signed [dtfa_pkg::MOM_W-1:0]    in_moment_y,
  input  logic signed [dtfa_pkg::MOM_W-1:0]    in_moment_z,
  input  logic                                 in_last_of_target,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [dtfa_pkg::FIELD_W-1:0]  out_field_x,
  output logic signed [dtfa_pkg::FIELD_W-1:0]  out_field_y,
  output logic signed [dtfa_pkg::FIELD_W-1:0]  out_field_z
);

  dtfa_pkg::dtfa_head_t head;
  logic                 pop;

  dtfa_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_cmd              (in_cmd),
    .in_entry_index      (in_entry_index),
    .in_component_select (in_component_select),
    .in_coefficient_word (in_coefficient_word),
    .in_sign_mask        (in_sign_mask),
    .in_skip_pair        (in_skip_pair),
    .in_moment_x         (in_moment_x),
    .in_moment_y         (in_moment_y),
    .in_moment_z         (in_moment_z),
    .in_last_of_target   (in_last_of_target),
    .head                (head),
    .pop                 (pop)
  );

  dtfa_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_field_x (out_field_x),
    .out_field_y (out_field_y),
    .out_field_z (out_field_z)
  );

endmodule
